/* design/lli_pkg.sv */
// ----------------------------------------------------------------------------
// lli_pkg
// Shared constants and types for the line-line intersection unit.
// ----------------------------------------------------------------------------
package lli_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int EPS_WIDTH           = 32;
   localparam logic [EPS_WIDTH-1:0] EPS_RESET = 32'd4295;
   localparam int MUL_CHUNK           = 32;

   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic hi_x;
      logic hi_y;
      logic parallel;
   } lli_flags_type;

endpackage

/* design/lli_mul.sv */
// ----------------------------------------------------------------------------
// lli_mul
// Two-stage signed multiplier: operand a is cut into chunks, one partial
// product per chunk in the first stage, shifted sum in the second.
// ----------------------------------------------------------------------------
module lli_mul #(
   parameter int WA = 32,
   parameter int WB = 32
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [WA-1:0]    a,
   input  logic signed [WB-1:0]    b,
   output logic signed [WA+WB-1:0] p
);

   localparam int CW  = lli_pkg::MUL_CHUNK;
   localparam int NC  = (WA + CW - 1) / CW;
   localparam int PPW = CW + 1 + WB;
   localparam int SW  = WA + WB + CW + 1;

   logic signed [CW:0]        chunk [NC];
   logic signed [PPW-1:0]     pp_ff [NC];
   logic signed [SW-1:0]      acc;
   logic signed [WA+WB-1:0]   p_in;
   logic signed [WA+WB-1:0]   p_ff;

   for (genvar k = 0; k < NC; k++) begin : g_chunk
      if (k < NC - 1) begin : g_lo
         assign chunk[k] = $signed({1'b0, a[CW*k +: CW]});
      end else begin : g_top
         assign chunk[k] = (CW+1)'($signed(a[WA-1:CW*k]));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NC; k++) begin
            pp_ff[k] <= chunk[k] * b;
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < NC; k++) begin
         acc = acc + (SW'(pp_ff[k]) <<< (CW * k));
      end
      p_in = acc[WA+WB-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

/* design/lli_div_cell.sv */
// ----------------------------------------------------------------------------
// lli_div_cell
// One restoring-division step for the x and y quotients: shifts one
// numerator bit into the remainder and retires one quotient bit.
// ----------------------------------------------------------------------------
module lli_div_cell #(
   parameter int DW = 67,
   parameter int QW = 32
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [DW-1:0]          src_d,
   input  logic [DW+QW-1:0]       src_rqx,
   input  logic [DW+QW-1:0]       src_rqy,
   input  lli_pkg::lli_flags_type src_flags,
   output logic [DW-1:0]          dst_d,
   output logic [DW+QW-1:0]       dst_rqx,
   output logic [DW+QW-1:0]       dst_rqy,
   output lli_pkg::lli_flags_type dst_flags
);

   logic [DW:0]           trial_x, trial_y, diff_x, diff_y;
   logic                  take_x, take_y;
   logic [DW-1:0]         d_ff;
   logic [DW+QW-1:0]      rqx_ff, rqy_ff, rqx_in, rqy_in;
   lli_pkg::lli_flags_type flags_ff;

   always_comb begin
      trial_x = {src_rqx[DW+QW-1:QW], src_rqx[QW-1]};
      trial_y = {src_rqy[DW+QW-1:QW], src_rqy[QW-1]};
      diff_x  = trial_x - {1'b0, src_d};
      diff_y  = trial_y - {1'b0, src_d};
      take_x  = trial_x >= {1'b0, src_d};
      take_y  = trial_y >= {1'b0, src_d};
      rqx_in  = {(take_x ? diff_x[DW-1:0] : trial_x[DW-1:0]), src_rqx[QW-2:0], take_x};
      rqy_in  = {(take_y ? diff_y[DW-1:0] : trial_y[DW-1:0]), src_rqy[QW-2:0], take_y};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff     <= src_d;
         rqx_ff   <= rqx_in;
         rqy_ff   <= rqy_in;
         flags_ff <= src_flags;
      end
   end

   assign dst_d     = d_ff;
   assign dst_rqx   = rqx_ff;
   assign dst_rqy   = rqy_ff;
   assign dst_flags = flags_ff;

endmodule

/* design/line_line_intersection_unit.sv */
// ----------------------------------------------------------------------------
// line_line_intersection_unit
// Intersection of two lines by Cramer's rule in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one line pair per cycle while the pipe is not stalled and returns
// the results in order. The pipe is the divide chain, one cell per
// quotient bit, COORD_WIDTH cells, preceded by nine stages of input
// registers, differences, chunked multiplies and magnitude and range
// checks, and followed by the output register. The whole pipe advances
// when the output register is empty or being taken. All products are
// exact; quotients truncate toward zero and saturate with overflow set.
// Pairs whose determinant magnitude is at or below the epsilon written
// through the CSR port give zero coordinates with parallel set.
module line_line_intersection_unit #(
   parameter int COORD_WIDTH = lli_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_line1_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_line1_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_line1_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_line1_end_y,
   input  logic signed [COORD_WIDTH-1:0] req_line2_start_x,
   input  logic signed [COORD_WIDTH-1:0] req_line2_start_y,
   input  logic signed [COORD_WIDTH-1:0] req_line2_end_x,
   input  logic signed [COORD_WIDTH-1:0] req_line2_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_x,
   output logic signed [COORD_WIDTH-1:0] rsp_cross_y,
   output logic                          rsp_parallel,
   output logic                          rsp_overflow,
   input  logic                          csr_write_en,
   input  logic [lli_pkg::EPS_WIDTH-1:0] csr_write_data
);

   localparam int W     = COORD_WIDTH;
   localparam int AW    = W + 1;
   localparam int PW    = 2 * W;
   localparam int CWD   = 2 * W + 1;
   localparam int DW    = 2 * W + 3;
   localparam int NW    = 3 * W + 3;
   localparam int DEPTH = W + 10;
   localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};

   logic                          en;
   logic [DEPTH-1:0]              v_ff, v_in;
   logic [lli_pkg::EPS_WIDTH-1:0] eps_ff;

   logic signed [W-1:0]    x1s_ff, y1s_ff, x1e_ff, y1e_ff;
   logic signed [W-1:0]    x2s_ff, y2s_ff, x2e_ff, y2e_ff;
   logic signed [AW-1:0]   a1_2_ff, b1_2_ff, a2_2_ff, b2_2_ff;
   logic signed [AW-1:0]   a1_3_ff, b1_3_ff, a2_3_ff, b2_3_ff;
   logic signed [AW-1:0]   a1_4_ff, b1_4_ff, a2_4_ff, b2_4_ff;
   logic signed [CWD-1:0]  c1_4_ff, c2_4_ff;
   logic signed [DW-1:0]   det_5_ff, det_6_ff, det_7_ff;
   logic signed [NW-1:0]   nx_7_ff, ny_7_ff;
   logic [NW-1:0]          nx_mag_ff, ny_mag_ff;
   logic [DW-1:0]          d_mag_ff;
   logic                   neg_x_ff, neg_y_ff;
   logic [DW-1:0]          d_9_ff;
   logic [NW-1:0]          rqx_9_ff, rqy_9_ff;
   lli_pkg::lli_flags_type flags_9_ff;

   logic signed [PW-1:0]   p_x1s_y1e, p_y1s_x1e, p_x2s_y2e, p_y2s_x2e;
   logic signed [2*AW-1:0] p_a1b2, p_a2b1;
   logic signed [CWD+AW-1:0] p_c1b2, p_c2b1, p_c2a1, p_c1a2;

   logic [DW-1:0]          ch_d     [W+1];
   logic [NW-1:0]          ch_rqx   [W+1];
   logic [NW-1:0]          ch_rqy   [W+1];
   lli_pkg::lli_flags_type ch_flags [W+1];

   logic [W-1:0]           qx, qy, lim_x, lim_y, mag_x, mag_y;
   logic                   ovf_x, ovf_y;
   logic signed [W-1:0]    cross_x_ff, cross_y_ff, cross_x_in, cross_y_in;
   logic                   parallel_ff, overflow_ff, parallel_in, overflow_in;

   assign en        = !v_ff[DEPTH-1] || rsp_ready;
   assign req_ready = en;
   assign v_in      = {v_ff[DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         eps_ff <= lli_pkg::EPS_RESET;
      end else begin
         if (en) begin
            v_ff <= v_in;
         end
         if (csr_write_en) begin
            eps_ff <= csr_write_data;
         end
      end
   end

   lli_mul #(.WA(W), .WB(W)) u_mul_c1a (
      .clock(clock), .en(en), .a(x1s_ff), .b(y1e_ff), .p(p_x1s_y1e));
   lli_mul #(.WA(W), .WB(W)) u_mul_c1b (
      .clock(clock), .en(en), .a(y1s_ff), .b(x1e_ff), .p(p_y1s_x1e));
   lli_mul #(.WA(W), .WB(W)) u_mul_c2a (
      .clock(clock), .en(en), .a(x2s_ff), .b(y2e_ff), .p(p_x2s_y2e));
   lli_mul #(.WA(W), .WB(W)) u_mul_c2b (
      .clock(clock), .en(en), .a(y2s_ff), .b(x2e_ff), .p(p_y2s_x2e));
   lli_mul #(.WA(AW), .WB(AW)) u_mul_a1b2 (
      .clock(clock), .en(en), .a(a1_2_ff), .b(b2_2_ff), .p(p_a1b2));
   lli_mul #(.WA(AW), .WB(AW)) u_mul_a2b1 (
      .clock(clock), .en(en), .a(a2_2_ff), .b(b1_2_ff), .p(p_a2b1));
   lli_mul #(.WA(CWD), .WB(AW)) u_mul_c1b2 (
      .clock(clock), .en(en), .a(c1_4_ff), .b(b2_4_ff), .p(p_c1b2));
   lli_mul #(.WA(CWD), .WB(AW)) u_mul_c2b1 (
      .clock(clock), .en(en), .a(c2_4_ff), .b(b1_4_ff), .p(p_c2b1));
   lli_mul #(.WA(CWD), .WB(AW)) u_mul_c2a1 (
      .clock(clock), .en(en), .a(c2_4_ff), .b(a1_4_ff), .p(p_c2a1));
   lli_mul #(.WA(CWD), .WB(AW)) u_mul_c1a2 (
      .clock(clock), .en(en), .a(c1_4_ff), .b(a2_4_ff), .p(p_c1a2));

   always_ff @(posedge clock) begin
      if (en) begin
         x1s_ff <= req_line1_start_x;
         y1s_ff <= req_line1_start_y;
         x1e_ff <= req_line1_end_x;
         y1e_ff <= req_line1_end_y;
         x2s_ff <= req_line2_start_x;
         y2s_ff <= req_line2_start_y;
         x2e_ff <= req_line2_end_x;
         y2e_ff <= req_line2_end_y;

         a1_2_ff <= AW'(y1e_ff) - AW'(y1s_ff);
         b1_2_ff <= AW'(x1s_ff) - AW'(x1e_ff);
         a2_2_ff <= AW'(y2e_ff) - AW'(y2s_ff);
         b2_2_ff <= AW'(x2s_ff) - AW'(x2e_ff);

         a1_3_ff <= a1_2_ff;
         b1_3_ff <= b1_2_ff;
         a2_3_ff <= a2_2_ff;
         b2_3_ff <= b2_2_ff;

         a1_4_ff <= a1_3_ff;
         b1_4_ff <= b1_3_ff;
         a2_4_ff <= a2_3_ff;
         b2_4_ff <= b2_3_ff;
         c1_4_ff <= CWD'(p_x1s_y1e) - CWD'(p_y1s_x1e);
         c2_4_ff <= CWD'(p_x2s_y2e) - CWD'(p_y2s_x2e);

         det_5_ff <= DW'(p_a1b2) - DW'(p_a2b1);
         det_6_ff <= det_5_ff;
         det_7_ff <= det_6_ff;
         nx_7_ff  <= NW'(p_c1b2) - NW'(p_c2b1);
         ny_7_ff  <= NW'(p_c2a1) - NW'(p_c1a2);

         nx_mag_ff <= nx_7_ff[NW-1] ? NW'(-nx_7_ff) : NW'(nx_7_ff);
         ny_mag_ff <= ny_7_ff[NW-1] ? NW'(-ny_7_ff) : NW'(ny_7_ff);
         d_mag_ff  <= det_7_ff[DW-1] ? DW'(-det_7_ff) : DW'(det_7_ff);
         neg_x_ff  <= nx_7_ff[NW-1] ^ det_7_ff[DW-1];
         neg_y_ff  <= ny_7_ff[NW-1] ^ det_7_ff[DW-1];

         d_9_ff              <= d_mag_ff;
         rqx_9_ff            <= nx_mag_ff;
         rqy_9_ff            <= ny_mag_ff;
         flags_9_ff.neg_x    <= neg_x_ff;
         flags_9_ff.neg_y    <= neg_y_ff;
         flags_9_ff.hi_x     <= nx_mag_ff[NW-1:W] >= d_mag_ff;
         flags_9_ff.hi_y     <= ny_mag_ff[NW-1:W] >= d_mag_ff;
         flags_9_ff.parallel <= d_mag_ff <= DW'(eps_ff);
      end
   end

   assign ch_d[0]     = d_9_ff;
   assign ch_rqx[0]   = rqx_9_ff;
   assign ch_rqy[0]   = rqy_9_ff;
   assign ch_flags[0] = flags_9_ff;

   for (genvar k = 0; k < W; k++) begin : g_cell
      lli_div_cell #(.DW(DW), .QW(W)) u_cell (
         .clock     (clock),
         .en        (en),
         .src_d     (ch_d[k]),
         .src_rqx   (ch_rqx[k]),
         .src_rqy   (ch_rqy[k]),
         .src_flags (ch_flags[k]),
         .dst_d     (ch_d[k+1]),
         .dst_rqx   (ch_rqx[k+1]),
         .dst_rqy   (ch_rqy[k+1]),
         .dst_flags (ch_flags[k+1])
      );
   end

   always_comb begin
      qx    = ch_rqx[W][W-1:0];
      qy    = ch_rqy[W][W-1:0];
      lim_x = ch_flags[W].neg_x ? NEG_LIM : POS_LIM;
      lim_y = ch_flags[W].neg_y ? NEG_LIM : POS_LIM;
      ovf_x = ch_flags[W].hi_x || (qx > lim_x);
      ovf_y = ch_flags[W].hi_y || (qy > lim_y);
      mag_x = ovf_x ? lim_x : qx;
      mag_y = ovf_y ? lim_y : qy;
      if (ch_flags[W].parallel) begin
         cross_x_in  = '0;
         cross_y_in  = '0;
         parallel_in = 1'b1;
         overflow_in = 1'b0;
      end else begin
         cross_x_in  = ch_flags[W].neg_x ? $signed(-mag_x) : $signed(mag_x);
         cross_y_in  = ch_flags[W].neg_y ? $signed(-mag_y) : $signed(mag_y);
         parallel_in = 1'b0;
         overflow_in = ovf_x || ovf_y;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cross_x_ff  <= cross_x_in;
         cross_y_ff  <= cross_y_in;
         parallel_ff <= parallel_in;
         overflow_ff <= overflow_in;
      end
   end

   assign rsp_valid    = v_ff[DEPTH-1];
   assign rsp_cross_x  = cross_x_ff;
   assign rsp_cross_y  = cross_y_ff;
   assign rsp_parallel = parallel_ff;
   assign rsp_overflow = overflow_ff;

   a_parallel_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parallel |-> rsp_cross_x == '0 && rsp_cross_y == '0 && !rsp_overflow)
      else $error("parallel result with nonzero payload");

   a_overflow_saturated : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_cross_x == $signed(POS_LIM) || rsp_cross_x == $signed(NEG_LIM) ||
         rsp_cross_y == $signed(POS_LIM) || rsp_cross_y == $signed(NEG_LIM))
      else $error("overflow without a saturated coordinate");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(v_ff))
      else $error("pipeline moved while stalled");

endmodule
